FILE: rtl/core/lia_pkg.sv
// Shared types and constants for the line intersection unit.
// Holds the fixed-point widths and the record that travels down the divider chain.
// No dependencies.
package lia_pkg;

	localparam int SLOPE_FRAC_BITS = 30;
	localparam int SLOPE_W = 32;
	localparam int COORD_W = 32;
	localparam int TOL_W   = 31;
	localparam int PROD_W  = 64;
	localparam int NUM_W   = 96;
	localparam int DEN_W   = 64;
	localparam int QUOT_W  = 33;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [QUOT_W-1:0] SAT_POS = 33'h0_7FFF_FFFF;
	localparam logic [QUOT_W-1:0] SAT_NEG = 33'h0_8000_0000;
	localparam logic [TOL_W-1:0]  TOL_RESET = 31'd1;

	typedef enum logic [0:0] {
		REG_PARALLEL_TOLERANCE = 1'b0
	} reg_idx_t;

	// one item in flight through the division cells
	typedef struct packed {
		logic              par;
		logic              zero_den;
		logic              x_neg;
		logic              y_neg;
		logic              x_sat;
		logic              y_sat;
		logic [DEN_W-1:0]  den;
		logic [DEN_W-1:0]  x_rem;
		logic [DEN_W-1:0]  y_rem;
		logic [QUOT_W-1:0] x_low;
		logic [QUOT_W-1:0] y_low;
		logic [QUOT_W-1:0] x_q;
		logic [QUOT_W-1:0] y_q;
	} cell_t;

endpackage

FILE: rtl/core/lia_front.sv
// Front end of the line intersection unit: products, parallel test, numerators.
// Five stages that hand a cell_t record to the division chain; uses lia_pkg.
module lia_front import lia_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [SLOPE_W-1:0] first_slope,
	input  logic signed [COORD_W-1:0] first_intercept,
	input  logic                      first_inverted,
	input  logic signed [SLOPE_W-1:0] second_slope,
	input  logic signed [COORD_W-1:0] second_intercept,
	input  logic                      second_inverted,
	input  logic [TOL_W-1:0]          tol,
	output logic                      valid_s5,
	output cell_t                     cell_s5
);

	localparam int S  = SLOPE_FRAC_BITS;
	localparam int DW = SLOPE_W + 1;

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	// stage 1: input register
	logic signed [SLOPE_W-1:0] m1_s1, m2_s1;
	logic signed [COORD_W-1:0] b1_s1, b2_s1;
	logic                      i1_s1, i2_s1;
	logic [SLOPE_W-1:0]        m2_abs_s1;

	// stage 2: products and differences
	logic signed [PROD_W-1:0]  m1b2_s2, m2b1_s2, m1m2_s2;
	logic [PROD_W-2:0]         ptol_s2;
	logic signed [DW-1:0]      dm_s2, db_s2;
	logic signed [COORD_W-1:0] b1_s2, b2_s2;
	logic                      i1_s2, i2_s2, m2z_s2;
	logic [SLOPE_W-1:0]        m2_abs;

	// stage 3: numerators, denominator, parallel operands
	logic signed [NUM_W-1:0]   xn_s3, yn_s3;
	logic signed [DEN_W:0]     den_s3, lhs_s3;
	logic [PROD_W-2:0]         ptol_s3;
	logic [DW-1:0]             dm_abs_s3;
	logic                      same_s3, m2z_s3;
	logic signed [NUM_W-1:0]   xn_c, yn_c;
	logic signed [DEN_W:0]     den_c;
	logic signed [PROD_W-1:0]  dc, ae;
	logic signed [COORD_W-1:0] cc, ee;

	// stage 4: magnitudes and signs
	logic [NUM_W-1:0]          xm_s4, ym_s4;
	logic [DEN_W-1:0]          dmag_s4;
	logic                      xneg_s4, yneg_s4, par_s4;
	logic [DEN_W:0]            lhs_abs;
	logic                      par_c;

	assign m2_abs = second_slope[SLOPE_W-1] ? SLOPE_W'(-second_slope) : second_slope;

	// numerators for both forms
	always_comb begin
		dc = i1_s2 ? m1b2_s2 : m2b1_s2;
		ae = i1_s2 ? m2b1_s2 : m1b2_s2;
		cc = i1_s2 ? b2_s2 : b1_s2;
		ee = i1_s2 ? b1_s2 : b2_s2;
		if (i1_s2 == i2_s2) begin
			den_c = (DEN_W+1)'(dm_s2);
			if (i1_s2) begin
				yn_c = NUM_W'(db_s2) <<< S;
				xn_c = NUM_W'(m1b2_s2) - NUM_W'(m2b1_s2);
			end else begin
				xn_c = NUM_W'(db_s2) <<< S;
				yn_c = NUM_W'(m1b2_s2) - NUM_W'(m2b1_s2);
			end
		end else begin
			den_c = ((DEN_W+1)'(1) <<< (2*S)) - (DEN_W+1)'(m1m2_s2);
			xn_c  = (NUM_W'(dc) <<< S) + (NUM_W'(ee) <<< (2*S));
			yn_c  = (NUM_W'(ae) <<< S) + (NUM_W'(cc) <<< (2*S));
		end
	end

	// parallel decision
	always_comb begin
		lhs_abs = lhs_s3[DEN_W] ? (DEN_W+1)'(-lhs_s3) : lhs_s3;
		if (same_s3)
			par_c = dm_abs_s3 <= DW'(tol);
		else if (m2z_s3)
			par_c = 1'b0;
		else
			par_c = lhs_abs <= (DEN_W+1)'(ptol_s3);
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// advance the payload
	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1 <= first_slope;
			b1_s1 <= first_intercept;
			i1_s1 <= first_inverted;
			m2_s1 <= second_slope;
			b2_s1 <= second_intercept;
			i2_s1 <= second_inverted;

			m1b2_s2 <= PROD_W'(m1_s1) * PROD_W'(b2_s1);
			m2b1_s2 <= PROD_W'(m2_s1) * PROD_W'(b1_s1);
			m1m2_s2 <= PROD_W'(m1_s1) * PROD_W'(m2_s1);
			ptol_s2 <= (PROD_W-1)'(tol) * (PROD_W-1)'(m2_abs_s1);
			dm_s2   <= DW'(m1_s1) - DW'(m2_s1);
			db_s2   <= DW'(b2_s1) - DW'(b1_s1);
			b1_s2   <= b1_s1;
			b2_s2   <= b2_s1;
			i1_s2   <= i1_s1;
			i2_s2   <= i2_s1;
			m2z_s2  <= (m2_s1 == '0);

			xn_s3     <= xn_c;
			yn_s3     <= yn_c;
			den_s3    <= den_c;
			lhs_s3    <= (DEN_W+1)'(m1m2_s2) - ((DEN_W+1)'(1) <<< (2*S));
			ptol_s3   <= ptol_s2;
			dm_abs_s3 <= dm_s2[DW-1] ? DW'(-dm_s2) : dm_s2;
			same_s3   <= (i1_s2 == i2_s2);
			m2z_s3    <= m2z_s2;

			xm_s4   <= xn_s3[NUM_W-1] ? NUM_W'(-xn_s3) : xn_s3;
			ym_s4   <= yn_s3[NUM_W-1] ? NUM_W'(-yn_s3) : yn_s3;
			dmag_s4 <= den_s3[DEN_W] ? DEN_W'(-den_s3) : DEN_W'(den_s3);
			xneg_s4 <= xn_s3[NUM_W-1] ^ den_s3[DEN_W];
			yneg_s4 <= yn_s3[NUM_W-1] ^ den_s3[DEN_W];
			par_s4  <= par_c;

			cell_s5.par      <= par_s4;
			cell_s5.zero_den <= (dmag_s4 == '0);
			cell_s5.x_neg    <= xneg_s4;
			cell_s5.y_neg    <= yneg_s4;
			cell_s5.x_sat    <= {1'b0, xm_s4} >= {dmag_s4, {QUOT_W{1'b0}}};
			cell_s5.y_sat    <= {1'b0, ym_s4} >= {dmag_s4, {QUOT_W{1'b0}}};
			cell_s5.den      <= dmag_s4;
			cell_s5.x_rem    <= DEN_W'(xm_s4[NUM_W-1:QUOT_W]);
			cell_s5.y_rem    <= DEN_W'(ym_s4[NUM_W-1:QUOT_W]);
			cell_s5.x_low    <= xm_s4[QUOT_W-1:0];
			cell_s5.y_low    <= ym_s4[QUOT_W-1:0];
			cell_s5.x_q      <= '0;
			cell_s5.y_q      <= '0;
		end
	end

	// slope magnitude for the tolerance product
	always_ff @(posedge clk) begin
		if (en) begin
			m2_abs_s1 <= m2_abs;
		end
	end

endmodule

FILE: rtl/core/lia_div_cell.sv
// One restoring-division cell: retires one quotient bit of x and of y per beat.
// Identical cells are chained in the top level; uses lia_pkg.
module lia_div_cell import lia_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  valid_in,
	input  cell_t cell_in,
	output logic  valid_q,
	output cell_t cell_q
);

	logic [DEN_W:0]   sh_x, sh_y;
	logic [DEN_W+1:0] df_x, df_y;
	logic             ge_x, ge_y;
	cell_t            cell_nxt;

	// shift in the next numerator bit and try the subtract
	always_comb begin
		sh_x = {cell_in.x_rem, cell_in.x_low[QUOT_W-1]};
		sh_y = {cell_in.y_rem, cell_in.y_low[QUOT_W-1]};
		df_x = {1'b0, sh_x} - {2'b00, cell_in.den};
		df_y = {1'b0, sh_y} - {2'b00, cell_in.den};
		ge_x = !df_x[DEN_W+1];
		ge_y = !df_y[DEN_W+1];
	end

	// build the record for the next cell
	always_comb begin
		cell_nxt       = cell_in;
		cell_nxt.x_rem = ge_x ? df_x[DEN_W-1:0] : sh_x[DEN_W-1:0];
		cell_nxt.y_rem = ge_y ? df_y[DEN_W-1:0] : sh_y[DEN_W-1:0];
		cell_nxt.x_low = cell_in.x_low << 1;
		cell_nxt.y_low = cell_in.y_low << 1;
		cell_nxt.x_q   = {cell_in.x_q[QUOT_W-2:0], ge_x};
		cell_nxt.y_q   = {cell_in.y_q[QUOT_W-2:0], ge_y};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	// hand the record to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= cell_nxt;
		end
	end

endmodule

FILE: rtl/core/line_intersection_unit.sv
// Line intersection unit: crossing point of two lines or a parallel flag.
// Pipeline: 5 front stages, 33 division cells (one quotient bit each) and the output
// register. Throughput one pair per cycle while the output is not stalled.
// A stalled output holds the whole pipeline. Reset clears all valid bits and sets
// parallel_tolerance to 1. Depends on lia_pkg, lia_front and lia_div_cell.
module line_intersection_unit import lia_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_AW-1:0]         paddr,
	input  logic [APB_DW-1:0]         pwdata,
	output logic [APB_DW-1:0]         prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [SLOPE_W-1:0] first_slope,
	input  logic signed [COORD_W-1:0] first_intercept,
	input  logic                      first_inverted,
	input  logic signed [SLOPE_W-1:0] second_slope,
	input  logic signed [COORD_W-1:0] second_intercept,
	input  logic                      second_inverted,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      status,
	output logic signed [COORD_W-1:0] cross_x,
	output logic signed [COORD_W-1:0] cross_y
);

	logic [TOL_W-1:0]  tol_q;
	logic              en;
	logic              out_valid_q, status_q;
	logic [COORD_W-1:0] cross_x_q, cross_y_q;
	logic [QUOT_W:0]   vchain;
	cell_t             cchain [QUOT_W+1];
	cell_t             last;
	logic [QUOT_W-1:0] lim_x, lim_y, m_x, m_y, v_x, v_y;
	reg_idx_t          reg_idx;

	// register port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign prdata  = (reg_idx == REG_PARALLEL_TOLERANCE) ? APB_DW'(tol_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && pready
				&& reg_idx == REG_PARALLEL_TOLERANCE) begin
			tol_q <= pwdata[TOL_W-1:0];
		end
	end

	// hold everything while the output beat waits
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	lia_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.in_valid         (in_valid),
		.first_slope      (first_slope),
		.first_intercept  (first_intercept),
		.first_inverted   (first_inverted),
		.second_slope     (second_slope),
		.second_intercept (second_intercept),
		.second_inverted  (second_inverted),
		.tol              (tol_q),
		.valid_s5         (vchain[0]),
		.cell_s5          (cchain[0])
	);

	// division chain, one quotient bit per cell
	for (genvar k = 0; k < QUOT_W; k++) begin : g_cell
		lia_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (vchain[k]),
			.cell_in  (cchain[k]),
			.valid_q  (vchain[k+1]),
			.cell_q   (cchain[k+1])
		);
	end

	// saturate and apply sign
	always_comb begin
		last  = cchain[QUOT_W];
		lim_x = last.x_neg ? SAT_NEG : SAT_POS;
		lim_y = last.y_neg ? SAT_NEG : SAT_POS;
		m_x   = (last.x_sat || last.x_q > lim_x) ? lim_x : last.x_q;
		m_y   = (last.y_sat || last.y_q > lim_y) ? lim_y : last.y_q;
		v_x   = last.x_neg ? QUOT_W'(-m_x) : m_x;
		v_y   = last.y_neg ? QUOT_W'(-m_y) : m_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vchain[QUOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q  <= last.par;
			cross_x_q <= (last.par || last.zero_den) ? '0 : v_x[COORD_W-1:0];
			cross_y_q <= (last.par || last.zero_den) ? '0 : v_y[COORD_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign cross_x   = cross_x_q;
	assign cross_y   = cross_y_q;

endmodule

FILE: rtl/core/lia_checker.sv
// Port-level checks for the line intersection unit, bound to the top level.
// Depends on lia_pkg and line_intersection_unit.
module lia_checker import lia_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               status,
	input logic [COORD_W-1:0] cross_x,
	input logic [COORD_W-1:0] cross_y
);

	// input is held only behind a waiting output beat
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a waiting output beat");

	// a parallel result carries zero coordinates
	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (cross_x == '0 && cross_y == '0))
		else $error("parallel result with nonzero coordinates");

	// a stalled beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("output beat dropped while stalled");

	// a stalled payload does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(status) && $stable(cross_x) && $stable(cross_y)))
		else $error("output payload changed while stalled");

endmodule

bind line_intersection_unit lia_checker u_lia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.cross_x   (cross_x),
	.cross_y   (cross_y)
);
